>>> rtl/wsu_pkg.sv
// wsu_pkg: shared types, register and format codes, and G.711 expansion
// functions for the WAV sample unpacker. No dependencies.
`default_nettype none

package wsu_pkg;

   // Frame store slots per bank, default
   localparam int MAX_CHANNELS = 8;

   // Register map and widths
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 4;
   localparam logic [CSR_INDEX_W-1:0] REG_SAMPLE_FORMAT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PCM_WIDTH     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

   // sample_format codes (code 3 falls back to linear PCM)
   localparam logic [1:0] FMT_PCM  = 2'd0;
   localparam logic [1:0] FMT_ALAW = 2'd1;
   localparam logic [1:0] FMT_ULAW = 2'd2;

   // pcm_width codes (code 3 acts as 24-bit)
   localparam logic [1:0] WID_8  = 2'd0;
   localparam logic [1:0] WID_16 = 2'd1;
   localparam logic [1:0] WID_24 = 2'd2;

   // Reset values of the registers
   localparam logic [1:0] FORMAT_RESET = FMT_PCM;
   localparam logic [1:0] WIDTH_RESET  = WID_16;
   localparam logic [3:0] COUNT_RESET  = 4'd2;

   // Channel counts fit the 4-bit register; slots are carried at the widest
   localparam int CNT_W  = 4;
   localparam int SLOT_W = 5;

   // Output FIFO depth in the back end
   localparam int OUT_DEPTH = 4;

   // G.711 constants
   localparam logic [7:0]  ALAW_XOR  = 8'h55;
   localparam logic [7:0]  ULAW_XOR  = 8'hFF;
   localparam logic [15:0] ALAW_BIAS = 16'h0108;
   localparam logic [15:0] ULAW_BIAS = 16'd33;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       packet_last;
   } wsu_req_type;

   typedef struct packed {
      logic signed [23:0] sample;
      logic [2:0]         channel;
      logic               frame_last;
      logic               packet_end;
   } wsu_rsp_type;

   // One decoded sample headed for the frame store
   typedef struct packed {
      logic              en;
      logic              bank;
      logic [SLOT_W-1:0] slot;
      logic [23:0]       sample;
   } wsu_store_wr_type;

   // A completed frame waiting to drain
   typedef struct packed {
      logic             bank;
      logic [CNT_W-1:0] count;
      logic             packet_end;
   } wsu_desc_type;

   // A-law code to 16-bit linear, placed at 24-bit full scale
   function automatic logic [23:0] alaw_to_linear(input logic [7:0] code);
      logic [7:0]  v;
      logic [2:0]  seg;
      logic [15:0] mag;
      v   = code ^ ALAW_XOR;
      seg = v[6:4];
      mag = {8'h00, v[3:0], 4'h0};
      if (seg == 3'd0) begin
         mag = mag + 16'd8;
      end else begin
         mag = mag + ALAW_BIAS;
         mag = mag << (seg - 3'd1);
      end
      // sign bit clear means negative
      if (!v[7]) begin
         mag = ~mag + 16'd1;
      end
      return {mag, 8'h00};
   endfunction

   // mu-law code to 16-bit linear, placed at 24-bit full scale
   function automatic logic [23:0] ulaw_to_linear(input logic [7:0] code);
      logic [7:0]  v;
      logic [2:0]  seg;
      logic [15:0] mag;
      v   = code ^ ULAW_XOR;
      seg = v[6:4];
      mag = ULAW_BIAS + {11'h000, v[3:0], 1'b0};
      mag = (mag << seg) - ULAW_BIAS;
      mag = mag << 2;
      if (v[7]) begin
         mag = ~mag + 16'd1;
      end
      return {mag, 8'h00};
   endfunction

endpackage

`default_nettype wire

>>> rtl/wsu_front.sv
// wsu_front: configuration registers, byte assembly and sample decode.
// Writes samples into the back end's frame store and posts completed frames.
// Depends on wsu_pkg.
`default_nettype none

module wsu_front #(
   parameter int MAX_CHANNELS = wsu_pkg::MAX_CHANNELS
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // byte input
   input  wire logic                             push,
   input  wire wsu_pkg::wsu_req_type             req_data,
   input  wire logic                             accept,
   // configuration
   input  wire logic                             csr_wen,
   input  wire logic [wsu_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [wsu_pkg::CSR_DATA_W-1:0]   csr_wdata,
   // toward the back end
   output wsu_pkg::wsu_store_wr_type             store_wr,
   output logic                                  desc_push,
   output wsu_pkg::wsu_desc_type                 desc_word
);

   localparam int CW = wsu_pkg::CNT_W;

   logic [1:0]    sample_format_ff, sample_format_in;
   logic [1:0]    pcm_width_ff,     pcm_width_in;
   logic [CW-1:0] channel_count_ff, channel_count_in;
   logic [15:0]   held_ff,  held_in;
   logic [1:0]    phase_ff, phase_in;
   logic [CW-1:0] pos_ff,   pos_in;
   logic          bank_ff,  bank_in;

   logic [1:0]    bps;
   logic [CW-1:0] n_eff;
   logic          hold;
   logic [23:0]   sample;
   logic [CW:0]   pos_next;
   logic          frame_done;
   logic [CW-1:0] slot;
   logic          take;

   assign take = push & accept;

   // Register writes
   always_comb begin
      sample_format_in = sample_format_ff;
      pcm_width_in     = pcm_width_ff;
      channel_count_in = channel_count_ff;
      if (csr_wen) begin
         unique case (csr_index)
            wsu_pkg::REG_SAMPLE_FORMAT: sample_format_in = csr_wdata[1:0];
            wsu_pkg::REG_PCM_WIDTH:     pcm_width_in     = csr_wdata[1:0];
            wsu_pkg::REG_CHANNEL_COUNT: channel_count_in = csr_wdata[CW-1:0];
            default: ;
         endcase
      end
   end

   // Bytes per sample
   always_comb begin
      if (sample_format_ff == wsu_pkg::FMT_ALAW || sample_format_ff == wsu_pkg::FMT_ULAW) begin
         bps = 2'd1;
      end else begin
         unique case (pcm_width_ff)
            wsu_pkg::WID_8:  bps = 2'd1;
            wsu_pkg::WID_16: bps = 2'd2;
            default:         bps = 2'd3;
         endcase
      end
   end

   // Effective channel count: zero acts as one, saturate at the store size
   always_comb begin
      if (channel_count_ff == '0) begin
         n_eff = CW'(1);
      end else if ({2'b00, channel_count_ff} > 6'(MAX_CHANNELS)) begin
         n_eff = CW'(MAX_CHANNELS);
      end else begin
         n_eff = channel_count_ff;
      end
   end

   assign hold = ({1'b0, phase_ff} + 3'd1) < {1'b0, bps};

   // Decode the completing byte
   always_comb begin
      if (sample_format_ff == wsu_pkg::FMT_ALAW) begin
         sample = wsu_pkg::alaw_to_linear(req_data.data_byte);
      end else if (sample_format_ff == wsu_pkg::FMT_ULAW) begin
         sample = wsu_pkg::ulaw_to_linear(req_data.data_byte);
      end else if (bps == 2'd1) begin
         sample = {req_data.data_byte ^ 8'h80, 16'h0000};
      end else if (bps == 2'd2) begin
         sample = {req_data.data_byte, held_ff[7:0], 8'h00};
      end else begin
         sample = {req_data.data_byte, held_ff};
      end
   end

   // Slot in the frame, clamped to the store
   always_comb begin
      if ({2'b00, pos_ff} >= 6'(MAX_CHANNELS)) begin
         slot = CW'(MAX_CHANNELS - 1);
      end else begin
         slot = pos_ff;
      end
   end

   assign pos_next   = {1'b0, pos_ff} + (CW+1)'(1);
   assign frame_done = pos_next >= {1'b0, n_eff};

   // Assembly state
   always_comb begin
      held_in  = held_ff;
      phase_in = phase_ff;
      pos_in   = pos_ff;
      bank_in  = bank_ff;
      if (take) begin
         if (hold) begin
            if (phase_ff == 2'd0) begin
               held_in = {8'h00, req_data.data_byte};
            end else begin
               held_in = {req_data.data_byte, held_ff[7:0]};
            end
            phase_in = phase_ff + 2'd1;
         end else begin
            held_in  = '0;
            phase_in = '0;
            if (frame_done) begin
               pos_in  = '0;
               bank_in = ~bank_ff;
            end else begin
               pos_in = pos_next[CW-1:0];
            end
         end
         // packet end drops any partial sample or frame
         if (req_data.packet_last) begin
            held_in  = '0;
            phase_in = '0;
            pos_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_format_ff <= wsu_pkg::FORMAT_RESET;
         pcm_width_ff     <= wsu_pkg::WIDTH_RESET;
         channel_count_ff <= wsu_pkg::COUNT_RESET;
         held_ff          <= '0;
         phase_ff         <= '0;
         pos_ff           <= '0;
         bank_ff          <= 1'b0;
      end else begin
         sample_format_ff <= sample_format_in;
         pcm_width_ff     <= pcm_width_in;
         channel_count_ff <= channel_count_in;
         held_ff          <= held_in;
         phase_ff         <= phase_in;
         pos_ff           <= pos_in;
         bank_ff          <= bank_in;
      end
   end

   // Store write and frame post
   assign store_wr.en     = take & ~hold;
   assign store_wr.bank   = bank_ff;
   assign store_wr.slot   = wsu_pkg::SLOT_W'(slot);
   assign store_wr.sample = sample;

   assign desc_push            = take & ~hold & frame_done;
   assign desc_word.bank       = bank_ff;
   assign desc_word.count      = n_eff;
   assign desc_word.packet_end = req_data.packet_last;

endmodule

`default_nettype wire

>>> rtl/wsu_desc_queue.sv
// wsu_desc_queue: two-entry queue of completed frames between front and back.
// One entry per frame store bank. Depends on wsu_pkg.
`default_nettype none

module wsu_desc_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire wsu_pkg::wsu_desc_type push_word,
   input  wire logic                  pop,
   output logic                       full,
   output logic                       empty,
   output wsu_pkg::wsu_desc_type      head_word
);

   wsu_pkg::wsu_desc_type entry_ff [2];
   logic [1:0] count_ff, count_in;
   logic       head_ff,  head_in;
   logic       tail_ff,  tail_in;
   logic       do_push, do_pop;

   assign full      = count_ff == 2'd2;
   assign empty     = count_ff == 2'd0;
   assign head_word = entry_ff[head_ff];
   assign do_push   = push & ~full;
   assign do_pop    = pop & ~empty;

   // Pointers and fill count
   always_comb begin
      head_in  = do_pop  ? ~head_ff : head_ff;
      tail_in  = do_push ? ~tail_ff : tail_ff;
      count_in = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         head_ff  <= 1'b0;
         tail_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[tail_ff] <= push_word;
      end
   end

endmodule

`default_nettype wire

>>> rtl/wsu_back.sv
// wsu_back: double-banked frame store, frame drain sequencer and output FIFO.
// Depends on wsu_pkg.
`default_nettype none

module wsu_back #(
   parameter int MAX_CHANNELS = wsu_pkg::MAX_CHANNELS
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // from the front end
   input  wire wsu_pkg::wsu_store_wr_type store_wr,
   input  wire logic                      desc_empty,
   input  wire wsu_pkg::wsu_desc_type     desc_head,
   output logic                           desc_pop,
   // word output
   input  wire logic                      pop,
   output logic                           empty,
   output wsu_pkg::wsu_rsp_type           rsp_data
);

   localparam int CW       = wsu_pkg::CNT_W;
   localparam int PW       = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int DEPTH    = 2 * (2 ** PW);
   localparam int OD       = wsu_pkg::OUT_DEPTH;
   localparam int OPW      = $clog2(OD);
   localparam int OCW      = $clog2(OD + 1);
   localparam int SLOT_MSB = wsu_pkg::SLOT_W - 1;

   // Frame store, two banks
   logic [23:0] store_mem [DEPTH];
   logic [23:0] rd_data_ff;

   // Drain sequencer
   logic [CW-1:0] idx_ff, idx_in;
   logic          issue;
   logic          issue_last;
   logic [PW:0]   rd_addr;

   // Read stage tags
   logic          rd_valid_ff;
   logic [2:0]    rd_chan_ff;
   logic          rd_flast_ff;
   logic          rd_pend_ff;

   // Output FIFO
   wsu_pkg::wsu_rsp_type fifo_ff [OD];
   logic [OPW-1:0] fhead_ff, fhead_in;
   logic [OPW-1:0] ftail_ff, ftail_in;
   logic [OCW-1:0] fcount_ff, fcount_in;
   logic           fpush, fpop;
   logic [OCW:0]   credit_used;
   logic [SLOT_MSB:0] idx_wide;

   // Issue one read a cycle while a frame waits and the FIFO has room
   assign credit_used = {1'b0, fcount_ff} + {{OCW{1'b0}}, rd_valid_ff};
   assign issue       = ~desc_empty & (credit_used < (OCW+1)'(OD));
   assign issue_last  = idx_ff == (desc_head.count - CW'(1));
   assign desc_pop    = issue & issue_last;
   assign idx_wide    = wsu_pkg::SLOT_W'(idx_ff);
   assign rd_addr     = {desc_head.bank, idx_wide[PW-1:0]};

   always_comb begin
      idx_in = idx_ff;
      if (issue) begin
         idx_in = issue_last ? '0 : idx_ff + CW'(1);
      end
   end

   // Store write and registered read
   always_ff @(posedge clock) begin
      if (store_wr.en) begin
         store_mem[{store_wr.bank, store_wr.slot[PW-1:0]}] <= store_wr.sample;
      end
      if (issue) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   // Tags that travel with the read
   always_ff @(posedge clock) begin
      if (issue) begin
         rd_chan_ff  <= idx_ff[2:0];
         rd_flast_ff <= issue_last;
         rd_pend_ff  <= desc_head.packet_end;
      end
   end

   // FIFO pointers
   assign fpush = rd_valid_ff;
   assign fpop  = pop & ~empty;
   assign empty = fcount_ff == '0;

   always_comb begin
      fhead_in  = fpop  ? fhead_ff + OPW'(1) : fhead_ff;
      ftail_in  = fpush ? ftail_ff + OPW'(1) : ftail_ff;
      fcount_in = fcount_ff + OCW'(fpush) - OCW'(fpop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff      <= '0;
         rd_valid_ff <= 1'b0;
         fhead_ff    <= '0;
         ftail_ff    <= '0;
         fcount_ff   <= '0;
      end else begin
         idx_ff      <= idx_in;
         rd_valid_ff <= issue;
         fhead_ff    <= fhead_in;
         ftail_ff    <= ftail_in;
         fcount_ff   <= fcount_in;
      end
   end

   // FIFO storage
   always_ff @(posedge clock) begin
      if (fpush) begin
         fifo_ff[ftail_ff].sample     <= rd_data_ff;
         fifo_ff[ftail_ff].channel    <= rd_chan_ff;
         fifo_ff[ftail_ff].frame_last <= rd_flast_ff;
         fifo_ff[ftail_ff].packet_end <= rd_pend_ff;
      end
   end

   assign rsp_data = fifo_ff[fhead_ff];

endmodule

`default_nettype wire

>>> rtl/wav_sample_unpacker.sv
// Top level of the WAV sample unpacker: front end, frame queue, back end.
// Depends on wsu_pkg, wsu_front, wsu_desc_queue, wsu_back.
//
// Takes one packet byte per cycle while full is low and decodes linear PCM
// (8/16/24-bit, little-endian), G.711 A-law or mu-law into signed 24-bit
// samples. Each completed frame passes the frame queue, the registered
// store read and the output FIFO, and leaves as one word per effective
// channel, channel 0 first, one word per cycle while the FIFO has room;
// full rises only while two completed frames wait to drain (two store
// banks). Partial samples and frames at a packet end are dropped. The user
// must change configuration only while the block is idle; it is not enforced.
`default_nettype none

module wav_sample_unpacker #(
   parameter int MAX_CHANNELS = wsu_pkg::MAX_CHANNELS
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // byte input queue side
   input  wire logic                             push,
   output logic                                  full,
   input  wire wsu_pkg::wsu_req_type             req_data,
   // sample output queue side
   output logic                                  empty,
   input  wire logic                             pop,
   output wsu_pkg::wsu_rsp_type                  rsp_data,
   // configuration
   input  wire logic                             csr_wen,
   input  wire logic [wsu_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [wsu_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   wsu_pkg::wsu_store_wr_type store_wr;
   wsu_pkg::wsu_desc_type     desc_word;
   wsu_pkg::wsu_desc_type     desc_head;
   logic                      desc_push;
   logic                      desc_pop;
   logic                      desc_full;
   logic                      desc_empty;

   // Hold off bytes while both banks await drain
   assign full = desc_full;

   wsu_front #(
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .req_data  (req_data),
      .accept    (~desc_full),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .store_wr  (store_wr),
      .desc_push (desc_push),
      .desc_word (desc_word)
   );

   wsu_desc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (desc_push),
      .push_word (desc_word),
      .pop       (desc_pop),
      .full      (desc_full),
      .empty     (desc_empty),
      .head_word (desc_head)
   );

   wsu_back #(
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .store_wr   (store_wr),
      .desc_empty (desc_empty),
      .desc_head  (desc_head),
      .desc_pop   (desc_pop),
      .pop        (pop),
      .empty      (empty),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire
